[hw/rtl/stbl_pkg.sv]
`default_nettype none

package stbl_pkg;

    // Field widths fixed by the request and result formats.
    localparam int NODE_W = 6;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 16;
    localparam int VERD_W = 2;

    // Default number of nodes held in the budget table.
    localparam int NODE_COUNT_DEF = 64;

    // Entries in the request queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LEN      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD         = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_BUDGET = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_BUDGET    = 8'd3;

    localparam logic [TIME_W-1:0] RST_SLOT_LEN      = 32'd60000;
    localparam logic [TIME_W-1:0] RST_GUARD         = 32'd0;
    localparam logic [CNT_W-1:0]  RST_CLIENT_BUDGET = 16'd10;
    localparam logic [CNT_W-1:0]  RST_MIX_BUDGET    = 16'd2500;

    // Verdict codes.
    localparam logic [VERD_W-1:0] VERDICT_SPENT = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_HOLD  = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_GUARD = 2'd2;

    // Classified request as it travels from front to back.
    typedef struct packed {
        logic [NODE_W-1:0] node_id;
        logic              is_mix;
        logic [TIME_W-1:0] time_ms;
        logic              out_of_range;
    } t_req;

    // Live configuration; slot_len is already forced to at least one.
    typedef struct packed {
        logic [TIME_W-1:0] slot_len;
        logic [TIME_W-1:0] guard;
        logic [CNT_W-1:0]  client_budget;
        logic [CNT_W-1:0]  mix_budget;
    } t_cfg;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_RESOLVE
    } t_bk_state;

endpackage

`default_nettype wire

[hw/rtl/slotted_token_budget_limiter.sv]
`default_nettype none

// Channel     Direction  Handshake                         Payload
// s_axis      in         s_axis_tvalid / s_axis_tready     tdata: node_id, time_ms; tuser: mix
// m_axis      out        m_axis_tvalid / m_axis_tready     tdata: slot, count; tuser: verdict
// cfg         in         i_cfg_valid / o_cfg_ready         i_cfg_index, i_cfg_data
//
// Each request passes through the back end in order: a load, the bit-serial
// divide of time by slot length, and a resolve against the table.
// A two-entry queue takes requests while the back end divides, and the result
// register lets the next divide run while a result waits on m_axis_tready.
// Synchronous active-low reset empties the queue, clears the table valid bits
// and restores the register defaults; there is no clearing pass.

module slotted_token_budget_limiter #(
    parameter int NODE_COUNT = stbl_pkg::NODE_COUNT_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Request stream.
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [39:0]                         s_axis_tdata,  // node_id[5:0], time_ms[37:6]
    input  wire  [0:0]                          s_axis_tuser,  // node_is_mix[0]
    // Result stream.
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [47:0]                         m_axis_tdata,  // token_slot[31:0], spent_count[47:32]
    output logic [1:0]                          m_axis_tuser,  // verdict[1:0]
    // Configuration writes.
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [stbl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [stbl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [stbl_pkg::TIME_W-1:0] r_slot_len;
    logic [stbl_pkg::TIME_W-1:0] r_guard;
    logic [stbl_pkg::CNT_W-1:0]  r_client_budget;
    logic [stbl_pkg::CNT_W-1:0]  r_mix_budget;
    stbl_pkg::t_cfg              w_cfg;
    stbl_pkg::t_req              w_req;
    logic                        w_req_valid;
    logic                        w_req_pop;
    logic                        w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // Register file; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_len      <= stbl_pkg::RST_SLOT_LEN;
            r_guard         <= stbl_pkg::RST_GUARD;
            r_client_budget <= stbl_pkg::RST_CLIENT_BUDGET;
            r_mix_budget    <= stbl_pkg::RST_MIX_BUDGET;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                stbl_pkg::CFG_SLOT_LEN:      r_slot_len      <= i_cfg_data;
                stbl_pkg::CFG_GUARD:         r_guard         <= i_cfg_data;
                stbl_pkg::CFG_CLIENT_BUDGET: r_client_budget <= i_cfg_data[stbl_pkg::CNT_W-1:0];
                stbl_pkg::CFG_MIX_BUDGET:    r_mix_budget    <= i_cfg_data[stbl_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero slot length behaves as one millisecond.
    always_comb begin
        w_cfg.slot_len      = (r_slot_len == '0) ? stbl_pkg::TIME_W'(1) : r_slot_len;
        w_cfg.guard         = r_guard;
        w_cfg.client_budget = r_client_budget;
        w_cfg.mix_budget    = r_mix_budget;
    end

    stbl_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_node_id     (s_axis_tdata[5:0]),
        .i_node_is_mix (s_axis_tuser[0]),
        .i_time_ms     (s_axis_tdata[37:6]),
        .o_req         (w_req),
        .o_req_valid   (w_req_valid),
        .i_req_pop     (w_req_pop)
    );

    stbl_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_req         (w_req),
        .i_req_valid   (w_req_valid),
        .o_req_pop     (w_req_pop),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_verdict     (m_axis_tuser),
        .o_token_slot  (m_axis_tdata[31:0]),
        .o_spent_count (m_axis_tdata[47:32])
    );

endmodule

`default_nettype wire

[hw/rtl/stbl_front.sv]
`default_nettype none

module stbl_front #(
    parameter int NODE_COUNT = stbl_pkg::NODE_COUNT_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire  [stbl_pkg::NODE_W-1:0]     i_node_id,
    input  wire                             i_node_is_mix,
    input  wire  [stbl_pkg::TIME_W-1:0]     i_time_ms,
    output stbl_pkg::t_req                  o_req,
    output logic                            o_req_valid,
    input  wire                             i_req_pop
);

    localparam int QPTR_W = (stbl_pkg::QUEUE_DEPTH > 1) ? $clog2(stbl_pkg::QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(stbl_pkg::QUEUE_DEPTH + 1);

    stbl_pkg::t_req     r_queue [stbl_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    stbl_pkg::t_req     w_req;
    logic               w_push;
    logic               w_pop;

    // Classify the incoming request: nodes beyond the table are refused later.
    always_comb begin
        w_req.node_id      = i_node_id;
        w_req.is_mix       = i_node_is_mix;
        w_req.time_ms      = i_time_ms;
        w_req.out_of_range = (32'(i_node_id) >= 32'(NODE_COUNT));
    end

    assign o_ready     = (r_count != QCNT_W'(stbl_pkg::QUEUE_DEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_req_valid = (r_count != '0);
    assign w_pop       = i_req_pop && o_req_valid;
    assign o_req       = r_queue[r_rd_ptr];

    // Pointer wrap for the queue.
    always_comb begin
        n_wr_ptr = (r_wr_ptr == QPTR_W'(stbl_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == QPTR_W'(stbl_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_req;
        end
    end

    // Queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/stbl_back.sv]
`default_nettype none

module stbl_back #(
    parameter int NODE_COUNT = stbl_pkg::NODE_COUNT_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  stbl_pkg::t_cfg                  i_cfg,
    input  stbl_pkg::t_req                  i_req,
    input  wire                             i_req_valid,
    output logic                            o_req_pop,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [stbl_pkg::VERD_W-1:0]     o_verdict,
    output logic [stbl_pkg::TIME_W-1:0]     o_token_slot,
    output logic [stbl_pkg::CNT_W-1:0]      o_spent_count
);

    localparam int NODE_SPAN = 1 << stbl_pkg::NODE_W;
    localparam int TBL_DEPTH = (NODE_COUNT < NODE_SPAN) ? NODE_COUNT : NODE_SPAN;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int TW        = stbl_pkg::TIME_W;
    localparam int CW        = stbl_pkg::CNT_W;
    localparam int STEP_W    = $clog2(TW);

    stbl_pkg::t_bk_state r_state;
    stbl_pkg::t_bk_state n_state;

    // Request held for the duration of the division.
    logic [TBL_AW-1:0]   r_addr;
    logic                r_is_mix;
    logic                r_oor;

    // Restoring divider: r_quo starts as the dividend and ends as the quotient.
    logic [TW-1:0]       r_quo;
    logic [TW-1:0]       r_rem;
    logic [STEP_W-1:0]   r_step;
    logic [TW:0]         w_trial;
    logic                w_trial_ge;
    logic [TW:0]         w_trial_sub;

    // Per-node table and its valid bits.
    logic [TW-1:0]       r_mem_slot  [TBL_DEPTH];
    logic [CW-1:0]       r_mem_count [TBL_DEPTH];
    logic [TW-1:0]       r_rd_slot;
    logic [CW-1:0]       r_rd_count;
    logic [TBL_DEPTH-1:0] r_vld;

    // Output register.
    logic                r_out_valid;
    logic [stbl_pkg::VERD_W-1:0] r_out_verdict;
    logic [TW-1:0]       r_out_slot;
    logic [CW-1:0]       r_out_count;

    // Control strobes.
    logic                w_load;
    logic                w_step;
    logic                w_fire;
    logic                w_out_free;

    // Decision logic.
    logic [TW-1:0]       w_stored_slot;
    logic [CW-1:0]       w_stored_count;
    logic [CW-1:0]       w_cur_count;
    logic [CW-1:0]       w_budget;
    logic                w_guard_hit;
    logic                w_update;
    logic [stbl_pkg::VERD_W-1:0] w_verdict;
    logic [TW-1:0]       w_slot_res;
    logic [CW-1:0]       w_count_res;
    logic [CW-1:0]       w_count_wr;

    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stbl_pkg::BK_IDLE: begin
                if (i_req_valid) begin
                    n_state = stbl_pkg::BK_DIV;
                end
            end
            stbl_pkg::BK_DIV: begin
                if (r_step == STEP_W'(TW - 1)) begin
                    n_state = stbl_pkg::BK_RESOLVE;
                end
            end
            stbl_pkg::BK_RESOLVE: begin
                if (w_out_free) begin
                    n_state = stbl_pkg::BK_IDLE;
                end
            end
            default: n_state = stbl_pkg::BK_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        w_load = 1'b0;
        w_step = 1'b0;
        w_fire = 1'b0;
        unique case (r_state)
            stbl_pkg::BK_IDLE:    w_load = i_req_valid;
            stbl_pkg::BK_DIV:     w_step = 1'b1;
            stbl_pkg::BK_RESOLVE: w_fire = w_out_free;
            default: ;
        endcase
    end

    assign o_req_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stbl_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // One quotient bit per cycle.
    always_comb begin
        w_trial     = {r_rem, r_quo[TW-1]};
        w_trial_ge  = (w_trial >= {1'b0, i_cfg.slot_len});
        w_trial_sub = w_trial - {1'b0, i_cfg.slot_len};
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_quo    <= i_req.time_ms;
            r_rem    <= '0;
            r_step   <= '0;
            r_addr   <= i_req.node_id[TBL_AW-1:0];
            r_is_mix <= i_req.is_mix;
            r_oor    <= i_req.out_of_range;
        end else if (w_step) begin
            r_quo  <= {r_quo[TW-2:0], w_trial_ge};
            r_rem  <= w_trial_ge ? w_trial_sub[TW-1:0] : w_trial[TW-1:0];
            r_step <= r_step + 1'b1;
        end
    end

    // Decide the verdict once the quotient and remainder are ready.
    always_comb begin
        w_stored_slot  = r_vld[r_addr] ? r_rd_slot : '0;
        w_stored_count = r_vld[r_addr] ? r_rd_count : '0;
        w_cur_count    = (w_stored_slot == r_quo) ? w_stored_count : '0;
        w_budget       = r_is_mix ? i_cfg.mix_budget : i_cfg.client_budget;
        w_guard_hit    = (i_cfg.guard != '0)
                       && (({1'b0, r_rem} + {1'b0, i_cfg.guard}) >= {1'b0, i_cfg.slot_len});
        w_update       = 1'b0;
        w_count_wr     = w_cur_count;
        w_slot_res     = '0;
        w_count_res    = w_cur_count;
        if (r_oor) begin
            w_verdict   = stbl_pkg::VERDICT_HOLD;
            w_count_res = '0;
        end else if (w_guard_hit) begin
            w_verdict = stbl_pkg::VERDICT_GUARD;
        end else if (w_cur_count >= w_budget) begin
            // Refused, but a slot rollover still clears the stored count.
            w_verdict = stbl_pkg::VERDICT_HOLD;
            w_update  = 1'b1;
        end else begin
            w_verdict   = stbl_pkg::VERDICT_SPENT;
            w_update    = 1'b1;
            w_count_wr  = w_cur_count + 1'b1;
            w_slot_res  = r_quo;
            w_count_res = w_count_wr;
        end
    end

    // Table storage: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_fire && w_update) begin
            r_mem_slot[r_addr]  <= r_quo;
            r_mem_count[r_addr] <= w_count_wr;
        end
        r_rd_slot  <= r_mem_slot[r_addr];
        r_rd_count <= r_mem_count[r_addr];
    end

    // Valid bits stand in for the all-zero reset of the table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_fire && w_update) begin
            r_vld[r_addr] <= 1'b1;
        end
    end

    // Result register; the next request may be dividing while this waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_verdict <= w_verdict;
            r_out_slot    <= w_slot_res;
            r_out_count   <= w_count_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_verdict     = r_out_verdict;
    assign o_token_slot  = r_out_slot;
    assign o_spent_count = r_out_count;

`ifndef SYNTH
    // Only a spent token carries a slot index.
    a_slot_only_when_spent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_verdict != stbl_pkg::VERDICT_SPENT)) |-> (r_out_slot == '0))
        else $error("token slot set on a result that spent no token");

    // A spent token always leaves a nonzero count behind.
    a_spent_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_verdict == stbl_pkg::VERDICT_SPENT)) |-> (w_count_res != '0))
        else $error("spent token with zero count");

    // The divider must have finished with a remainder below the slot length.
    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stbl_pkg::BK_RESOLVE) |-> (r_rem < i_cfg.slot_len))
        else $error("divider remainder not below slot length");

    // A new request starts only after the previous result has been placed.
    a_load_after_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stbl_pkg::BK_RESOLVE && w_out_free) |=> (r_state == stbl_pkg::BK_IDLE))
        else $error("resolve did not hand over to idle");
`endif

endmodule

`default_nettype wire

[tb/sv/slotted_token_budget_limiter_test.sv]
`timescale 1ns / 1ps

module slotted_token_budget_limiter_test;

    localparam int NODES       = stbl_pkg::NODE_COUNT_DEF;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 145;
    localparam int LONG_HOLD   = 400;
    localparam int STUCK_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [stbl_pkg::NODE_W-1:0] node;
        logic                        mix;
        logic [stbl_pkg::TIME_W-1:0] now_ms;
    } t_request;

    typedef struct packed {
        logic [stbl_pkg::VERD_W-1:0] verdict;
        logic [stbl_pkg::TIME_W-1:0] slot;
        logic [stbl_pkg::CNT_W-1:0]  count;
    } t_grant;

    typedef enum logic {
        ROW_SETTING,
        ROW_REQUEST
    } t_row_kind;

    typedef struct {
        t_row_kind                       kind;
        logic [stbl_pkg::CFG_IDX_W-1:0]  idx;
        logic [stbl_pkg::CFG_DATA_W-1:0] data;
        t_request                        req;
        bit                              typed;
        t_grant                          want;
    } t_script_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [39:0]                     s_axis_tdata;   // node_id[5:0], time_ms[37:6]
    logic [0:0]                      s_axis_tuser;   // node_is_mix[0]
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [47:0]                     m_axis_tdata;   // token_slot[31:0], spent_count[47:32]
    logic [1:0]                      m_axis_tuser;   // verdict[1:0]
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [stbl_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [stbl_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the limiter's settings and per-node budget table.
    logic [stbl_pkg::TIME_W-1:0] slot_len_ms;
    logic [stbl_pkg::TIME_W-1:0] guard_ms;
    logic [stbl_pkg::CNT_W-1:0]  client_budget;
    logic [stbl_pkg::CNT_W-1:0]  mix_budget;
    logic [stbl_pkg::TIME_W-1:0] node_slot  [NODES];
    logic [stbl_pkg::CNT_W-1:0]  node_spent [NODES];

    t_grant      due_grants[$];
    t_script_row script[$];

    bit     pin_typed;
    t_grant pin_want;
    bit     hold_off_req;
    int     holds_done;
    int     errors;
    int     requests_taken;
    int     n_spent;
    int     n_hold;
    int     n_guard;
    int     stuck_cycles;

    slotted_token_budget_limiter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Free-running clock, 12 ns period.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Works out the verdict for one request and updates the shadow table.
    function automatic t_grant judge_request(t_request r);
        logic [stbl_pkg::TIME_W-1:0] len;
        logic [stbl_pkg::TIME_W-1:0] slot;
        logic [stbl_pkg::TIME_W-1:0] into;
        logic [stbl_pkg::CNT_W-1:0]  budget;
        t_grant                      g;
        len  = (slot_len_ms == '0) ? 32'd1 : slot_len_ms;
        slot = r.now_ms / len;
        into = r.now_ms % len;
        g    = '0;
        if (int'(r.node) >= NODES) begin
            g.verdict = stbl_pkg::VERDICT_HOLD;
            return g;
        end
        // Inside the guard band nothing changes; report the count only if the slot matches.
        if (guard_ms != '0 && ({32'd0, into} + {32'd0, guard_ms}) >= {32'd0, len}) begin
            g.verdict = stbl_pkg::VERDICT_GUARD;
            g.count   = (node_slot[r.node] == slot) ? node_spent[r.node] : '0;
            return g;
        end
        // A new slot clears the count, even if the request is then refused.
        if (node_slot[r.node] != slot) begin
            node_slot[r.node]  = slot;
            node_spent[r.node] = '0;
        end
        budget = r.mix ? mix_budget : client_budget;
        if (node_spent[r.node] >= budget) begin
            g.verdict = stbl_pkg::VERDICT_HOLD;
            g.count   = node_spent[r.node];
            return g;
        end
        node_spent[r.node] = node_spent[r.node] + 1'b1;
        g.verdict = stbl_pkg::VERDICT_SPENT;
        g.slot    = slot;
        g.count   = node_spent[r.node];
        return g;
    endfunction

    function automatic void apply_setting(logic [stbl_pkg::CFG_IDX_W-1:0] idx,
                                          logic [stbl_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            stbl_pkg::CFG_SLOT_LEN:      slot_len_ms   = data;
            stbl_pkg::CFG_GUARD:         guard_ms      = data;
            stbl_pkg::CFG_CLIENT_BUDGET: client_budget = data[stbl_pkg::CNT_W-1:0];
            stbl_pkg::CFG_MIX_BUDGET:    mix_budget    = data[stbl_pkg::CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [stbl_pkg::CFG_DATA_W-1:0] pick_budget();
        logic [stbl_pkg::CNT_W-1:0] b;
        case ($urandom_range(0, 5))
            0:       b = 16'd0;
            1:       b = 16'd1;
            2, 3:    b = 16'($urandom_range(2, 8));
            4:       b = 16'($urandom_range(9, 300));
            default: b = 16'hFFFF;
        endcase
        // Upper bits are junk that the register must drop.
        return {16'($urandom), b};
    endfunction

    function automatic void add_setting(logic [stbl_pkg::CFG_IDX_W-1:0] idx,
                                        logic [stbl_pkg::CFG_DATA_W-1:0] data);
        t_script_row row;
        row       = '{kind: ROW_SETTING, default: '0};
        row.idx   = idx;
        row.data  = data;
        script.insert(script.size(), row);
    endfunction

    function automatic void add_request(int node, bit mix, logic [stbl_pkg::TIME_W-1:0] t);
        t_script_row row;
        row      = '{kind: ROW_REQUEST, default: '0};
        row.req  = '{node: stbl_pkg::NODE_W'(node), mix: mix, now_ms: t};
        script.insert(script.size(), row);
    endfunction

    function automatic void add_typed(int node, bit mix, logic [stbl_pkg::TIME_W-1:0] t,
                                      logic [stbl_pkg::VERD_W-1:0] v,
                                      logic [stbl_pkg::TIME_W-1:0] s,
                                      logic [stbl_pkg::CNT_W-1:0] c);
        t_script_row row;
        row       = '{kind: ROW_REQUEST, default: '0};
        row.req   = '{node: stbl_pkg::NODE_W'(node), mix: mix, now_ms: t};
        row.typed = 1'b1;
        row.want  = '{verdict: v, slot: s, count: c};
        script.insert(script.size(), row);
    endfunction

    task automatic check_field(string what, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch: expected %0d (0x%h), got %0d (0x%h)",
                     $time, what, exp, exp, act, act);
            errors++;
        end
    endtask

    // Offers one request and holds it until the transfer takes place.
    task automatic offer_request(t_request r, bit typed, t_grant want);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r.now_ms, r.node};
        s_axis_tuser  <= r.mix;
        pin_typed = typed;
        pin_want  = want;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic pause_sender(int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stops offering and waits until every result due has come back.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_grants.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_setting(logic [stbl_pkg::CFG_IDX_W-1:0] idx,
                                 logic [stbl_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result receiver: changes its stall pattern now and then, and honours a long hold-off.
    initial begin : receiver
        int mode;
        int left;
        int tick;
        m_axis_tready <= 1'b0;
        mode = 0;
        left = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_off_req = 1'b0;
                holds_done++;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(30, 200);
                end
                left--;
                tick++;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 5) == 0);
                    default: m_axis_tready <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    // Watches every channel: predicts on each request transfer, checks each result
    // transfer, tracks settings, and gives up if things stop moving.
    always @(posedge i_clk) begin : monitor
        t_grant   got;
        t_grant   want;
        t_request req;
        bit       moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                moved       = 1'b1;
                got.verdict = m_axis_tuser;
                got.slot    = m_axis_tdata[31:0];
                got.count   = m_axis_tdata[47:32];
                case (got.verdict)
                    stbl_pkg::VERDICT_SPENT: n_spent++;
                    stbl_pkg::VERDICT_HOLD:  n_hold++;
                    stbl_pkg::VERDICT_GUARD: n_guard++;
                    default: ;
                endcase
                if (due_grants.size() == 0) begin
                    $display({"%0t: result with none due: expected nothing, ",
                              "got verdict %0d slot %0d count %0d"},
                             $time, got.verdict, got.slot, got.count);
                    errors++;
                end else begin
                    want = due_grants.pop_front();
                    check_field("verdict", 32'(want.verdict), 32'(got.verdict));
                    check_field("token_slot", want.slot, got.slot);
                    check_field("spent_count", 32'(want.count), 32'(got.count));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                req   = '{node: s_axis_tdata[5:0], mix: s_axis_tuser[0],
                          now_ms: s_axis_tdata[37:6]};
                want  = judge_request(req);
                if (pin_typed) want = pin_want;
                due_grants.insert(due_grants.size(), want);
                requests_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                apply_setting(i_cfg_index, i_cfg_data);
            end
            if (moved || (due_grants.size() == 0 && !s_axis_tvalid && !i_cfg_valid)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        t_request                    r;
        t_grant                      none;
        logic [stbl_pkg::TIME_W-1:0] len;
        logic [stbl_pkg::TIME_W-1:0] len_eff;
        logic [stbl_pkg::TIME_W-1:0] guard;
        logic [stbl_pkg::TIME_W-1:0] step_cap;
        logic [stbl_pkg::TIME_W-1:0] cur_time;
        int                          base_node;
        int                          burst_left;
        int                          roll;
        int                          gap;

        // Every input known from time zero; reset held low at the start, then released.
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        hold_off_req  = 1'b0;
        pin_typed     = 1'b0;
        pin_want      = '0;
        none          = '0;
        slot_len_ms   = stbl_pkg::RST_SLOT_LEN;
        guard_ms      = stbl_pkg::RST_GUARD;
        client_budget = stbl_pkg::RST_CLIENT_BUDGET;
        mix_budget    = stbl_pkg::RST_MIX_BUDGET;
        for (int n = 0; n < NODES; n++) begin
            node_slot[n]  = '0;
            node_spent[n] = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed script: defaults after reset, budget exhaustion and rollover,
        // guard band, zero and maximum slot length, ignored register indexes.
        add_typed(0, 1'b0, 32'd0, stbl_pkg::VERDICT_SPENT, 32'd0, 16'd1);
        add_typed(63, 1'b1, 32'hFFFF_FFFF, stbl_pkg::VERDICT_SPENT, 32'd71582, 16'd1);
        add_setting(stbl_pkg::CFG_CLIENT_BUDGET, 32'd2);
        add_typed(5, 1'b0, 32'd100, stbl_pkg::VERDICT_SPENT, 32'd0, 16'd1);
        add_request(5, 1'b0, 32'd200);
        add_typed(5, 1'b0, 32'd300, stbl_pkg::VERDICT_HOLD, 32'd0, 16'd2);
        add_request(5, 1'b0, 32'd60000);
        add_setting(stbl_pkg::CFG_CLIENT_BUDGET, 32'd0);
        add_typed(5, 1'b0, 32'd120000, stbl_pkg::VERDICT_HOLD, 32'd0, 16'd0);
        add_setting(stbl_pkg::CFG_MIX_BUDGET, 32'd0);
        add_typed(62, 1'b1, 32'd7, stbl_pkg::VERDICT_HOLD, 32'd0, 16'd0);
        add_setting(stbl_pkg::CFG_MIX_BUDGET, 32'hFFFF_FFFF);
        add_setting(stbl_pkg::CFG_CLIENT_BUDGET, 32'h0000_FFFF);
        add_request(5, 1'b0, 32'd120001);
        add_setting(stbl_pkg::CFG_GUARD, 32'd1000);
        add_request(7, 1'b1, 32'd121000);
        add_request(7, 1'b1, 32'd179000);
        add_request(7, 1'b1, 32'd239000);
        add_request(7, 1'b1, 32'd178999);
        add_setting(stbl_pkg::CFG_GUARD, 32'hFFFF_FFFF);
        add_request(0, 1'b0, 32'd0);
        add_request(63, 1'b1, 32'hFFFF_FFFF);
        add_setting(stbl_pkg::CFG_GUARD, 32'd0);
        add_setting(stbl_pkg::CFG_SLOT_LEN, 32'd0);
        add_typed(8, 1'b0, 32'hFFFF_FFFF, stbl_pkg::VERDICT_SPENT, 32'hFFFF_FFFF, 16'd1);
        add_request(8, 1'b0, 32'hFFFF_FFFF);
        add_setting(stbl_pkg::CFG_GUARD, 32'd1);
        add_request(8, 1'b0, 32'd5);
        add_setting(stbl_pkg::CFG_GUARD, 32'd0);
        add_setting(stbl_pkg::CFG_SLOT_LEN, 32'hFFFF_FFFF);
        add_request(9, 1'b1, 32'hFFFF_FFFE);
        add_typed(9, 1'b1, 32'hFFFF_FFFF, stbl_pkg::VERDICT_SPENT, 32'd1, 16'd1);
        add_setting(stbl_pkg::CFG_IDX_W'(4), 32'd1);
        add_setting(stbl_pkg::CFG_IDX_W'(255), 32'hFFFF_FFFF);
        add_request(9, 1'b1, 32'hFFFF_FFFF);

        foreach (script[k]) begin
            if (script[k].kind == ROW_SETTING) begin
                drain_results();
                write_setting(script[k].idx, script[k].data);
            end else begin
                offer_request(script[k].req, script[k].typed, script[k].want);
            end
        end
        drain_results();

        // Random phases, each under its own settings.
        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 6))
                0:       len = 32'd0;
                1:       len = 32'd1;
                2:       len = $urandom_range(2, 64);
                3:       len = $urandom_range(100, 5000);
                4:       len = 32'd60000;
                5:       len = 32'hFFFF_FFFF;
                default: len = $urandom;
            endcase
            len_eff = (len == '0) ? 32'd1 : len;
            case ($urandom_range(0, 7))
                0, 1, 2: guard = 32'd0;
                3, 4:    guard = $urandom_range(1, (len_eff >> 3) + 1);
                5:       guard = len_eff >> 1;
                6:       guard = len_eff;
                default: guard = 32'hFFFF_FFFF;
            endcase
            drain_results();
            write_setting(stbl_pkg::CFG_SLOT_LEN, len);
            write_setting(stbl_pkg::CFG_GUARD, guard);
            write_setting(stbl_pkg::CFG_CLIENT_BUDGET, pick_budget());
            write_setting(stbl_pkg::CFG_MIX_BUDGET, pick_budget());
            if ($urandom_range(0, 2) == 0)
                write_setting(stbl_pkg::CFG_IDX_W'($urandom_range(4, 255)), $urandom);

            // Mostly a small group of nodes walking forward in time, so that
            // budgets run out and slots roll over; the rest is scattered noise.
            base_node  = $urandom_range(0, NODES - 4);
            cur_time   = $urandom;
            step_cap   = (len_eff >> $urandom_range(1, 10)) + 1;
            burst_left = 0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (burst_left == 0) begin
                    case ($urandom_range(0, 3))
                        0:       gap = 0;
                        1:       gap = $urandom_range(1, 4);
                        2:       gap = $urandom_range(5, 40);
                        default: gap = $urandom_range(1, 12);
                    endcase
                    pause_sender(gap);
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    r.node   = stbl_pkg::NODE_W'($urandom_range(0, NODES - 1));
                    r.now_ms = $urandom;
                end else if (roll < 16) begin
                    // Time stepping backwards.
                    cur_time = cur_time - $urandom_range(0, step_cap);
                    r.node   = stbl_pkg::NODE_W'(base_node + $urandom_range(0, 3));
                    r.now_ms = cur_time;
                end else begin
                    if ($urandom_range(0, 2) != 0)
                        cur_time = cur_time + $urandom_range(0, step_cap);
                    r.node   = stbl_pkg::NODE_W'(base_node + $urandom_range(0, 3));
                    r.now_ms = cur_time;
                end
                r.mix = 1'($urandom_range(0, 1));
                offer_request(r, 1'b0, none);
                // Long receiver hold-off while requests keep coming, so the input backs up.
                if (phase == 2 && i == 10)
                    hold_off_req = 1'b1;
                // Mid-phase pause until everything due has come back.
                if (phase % 3 == 1 && i == PHASE_ITEMS / 2)
                    drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (due_grants.size() != 0) begin
            $display("%0t: %0d results still due at the end", $time, due_grants.size());
            errors++;
        end

        $display("Checked %0d requests: %0d spent, %0d held, %0d deferred by the guard band.",
                 requests_taken, n_spent, n_hold, n_guard);
        $display("Directed script plus %0d random setting phases, %0d long receiver hold-off(s).",
                 PHASES, holds_done);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/stbl_pkg.sv
hw/rtl/stbl_front.sv
hw/rtl/stbl_back.sv
hw/rtl/slotted_token_budget_limiter.sv
tb/sv/slotted_token_budget_limiter_test.sv
